// File: design/shtc_pkg.sv
// ----------------------------------------------------------------------------
// shtc_pkg: shared types, constants and helpers
// Fixed-point constants, register indexes and arithmetic helpers used by the
// temperature compensator and its shared units.
// ----------------------------------------------------------------------------
`default_nettype none

package shtc_pkg;

    localparam int unsigned MacAW  = 18;
    localparam int unsigned MacBW  = 34;
    localparam int unsigned MacAccW = MacAW + MacBW + 2;

    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [17:0] ALPHA_AMB  = 18'd13107;
    localparam logic [17:0] BETA_AMB   = 18'd52429;
    localparam logic [17:0] ALPHA_GRAD = 18'd1311;
    localparam logic [17:0] BETA_GRAD  = 18'd64225;
    localparam logic [16:0] SCALE_BASE = 17'd52429;
    localparam logic [13:0] SCALE_SPAN = 14'd13107;
    localparam logic signed [31:0] HALF_DEG_Q24 = 32'sd8388608;
    localparam logic signed [16:0] HALF_DEG_Q88 = 17'sd128;

    localparam logic [2:0] REG_CORR_EN  = 3'd0;
    localparam logic [2:0] REG_ACAL_EN  = 3'd1;
    localparam logic [2:0] REG_FACTOR   = 3'd2;
    localparam logic [2:0] REG_USER_COR = 3'd3;
    localparam logic [2:0] REG_DURATION = 3'd4;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_OK    = 2'd2;
    localparam logic [1:0] EV_ABORT = 2'd3;

    typedef struct packed {
        logic                     en;
        logic                     clr;
        logic signed [MacAW-1:0]  a;
        logic signed [MacBW-1:0]  b;
    } t_mac_op;

    function automatic logic [16:0] bright_scale(input logic [7:0] b);
        logic [21:0] v;
        logic [30:0] p;
        logic [21:0] q;
        logic [21:0] r;
        v = 22'(SCALE_SPAN * b);
        p = 31'(v * 9'd257);
        q = 22'(p >> 16);
        r = 22'(v - 22'(q * 8'd255));
        if (r >= 22'd255) begin
            q = q + 22'd1;
        end
        return 17'(SCALE_BASE + q[16:0]);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        if (v > 24'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [MacAccW-1:0] v);
        if (v > MacAccW'(64'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end else if (v < MacAccW'(-64'sh80000000)) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// File: design/self_heating_temp_compensator.sv
// ----------------------------------------------------------------------------
// self_heating_temp_compensator: ambient smoothing and self-heat correction
// Sequencer around one shared multiply-accumulate unit and a serial divider.
//
//   channel | valid   | stall     | words
//   input   | i_valid | o_stall   | one sample set
//   output  | o_valid | i_stall   | one corrected result
//   config  | i_cfg_we| -         | one register write
//
// A word runs through the sequencer steps from acceptance, and its result is then
// loaded into the output register; the next word is taken after the load. A word
// that ends calibration with a gradient above HALF_DEG_Q24 and a positive drift
// also waits for the serial divider.
// Synchronous active-low reset clears filters and calibration; factor is 0.
// The input is stalled whenever the sequencer is busy; a result waits in the
// output register while the next word is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module self_heating_temp_compensator
    import shtc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_ambient_temp,
    input  wire logic [16:0]        i_ambient_humidity,
    input  wire logic               i_read_failed,
    input  wire logic signed [15:0] i_core_temp,
    input  wire logic               i_core_present,
    input  wire logic signed [15:0] i_clock_temp,
    input  wire logic               i_clock_present,
    input  wire logic [7:0]         i_brightness,
    input  wire logic [31:0]        i_time_ms,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_compensated_temp,
    output logic signed [15:0]      o_smoothed_temp,
    output logic signed [15:0]      o_applied_offset,
    output logic [16:0]             o_humidity,
    output logic                    o_humidity_valid,
    output logic                    o_calibrating,
    output logic [1:0]              o_cal_event,
    output logic [16:0]             o_new_factor
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_AT0  = 4'd2;
    localparam logic [3:0] S_AT1  = 4'd3;
    localparam logic [3:0] S_AH0  = 4'd4;
    localparam logic [3:0] S_AH1  = 4'd5;
    localparam logic [3:0] S_AHW  = 4'd6;
    localparam logic [3:0] S_SM   = 4'd7;
    localparam logic [3:0] S_G0   = 4'd8;
    localparam logic [3:0] S_G1   = 4'd9;
    localparam logic [3:0] S_G2   = 4'd10;
    localparam logic [3:0] S_G3   = 4'd11;
    localparam logic [3:0] S_CAL  = 4'd12;
    localparam logic [3:0] S_DIV  = 4'd13;
    localparam logic [3:0] S_SH0  = 4'd14;
    localparam logic [3:0] S_SH1  = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_fin;

    logic              r_corr_en, r_acal_en;
    logic signed [12:0] r_ucorr;
    logic [31:0]       r_dur;
    logic [16:0]       r_factor;

    logic signed [15:0] r_amb, r_core, r_clk;
    logic [16:0]       r_hum;
    logic              r_fail, r_core_ok, r_clk_ok;
    logic [7:0]        r_bright;
    logic [16:0]       r_scale;
    logic [31:0]       r_now;

    logic signed [31:0] r_s, r_g;
    logic [32:0]       r_sh;
    logic              r_amb_started, r_grad_started, r_first_done, r_cal_run;
    logic [31:0]       r_cal_start;
    logic signed [15:0] r_base;
    logic signed [15:0] r_held_comp, r_held_off;
    logic [16:0]       r_hum_out;
    logic              r_hv;
    logic [1:0]        r_ev;

    t_mac_op                   mac_op;
    logic signed [MacAccW-1:0] acc;
    logic                      div_start, div_done;
    logic [16:0]               div_q;

    logic signed [15:0] smoothed;
    logic signed [16:0] cdiff;
    logic signed [17:0] eff, grad_in;
    logic signed [31:0] adj;
    logic [31:0]        elapsed;
    logic signed [16:0] cal_diff;
    logic signed [21:0] heat_loss;
    logic signed [23:0] offset, comp;

    assign smoothed = r_s[31:16];
    assign cdiff    = 17'(r_clk) - 17'(r_amb);
    assign eff      = (r_clk_ok && r_clk > 16'sd0)
                      ? 18'((18'(r_core) + 18'(r_clk) * 18'sd3) >>> 2) : 18'(r_core);
    assign grad_in  = eff - 18'(smoothed);
    assign adj      = sat32(acc);
    assign elapsed  = r_now - r_cal_start;
    assign cal_diff = 17'(smoothed) - 17'(r_base);
    assign heat_loss = acc[MacAccW-1] ? 22'sd0 : acc[53:32];
    assign offset   = 24'(r_ucorr) - 24'(heat_loss);
    assign comp     = 24'(smoothed) + offset;
    assign div_start = (r_state == S_CAL) && r_cal_run && (elapsed > r_dur)
                       && (r_g > HALF_DEG_Q24) && (cal_diff > 17'sd0);

    shtc_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .o_acc (acc)
    );

    shtc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cal_diff[16:0]),
        .i_divisor  (r_g),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        mac_op = '{en: 1'b0, clr: 1'b0, a: '0, b: '0};
        unique case (r_state)
            S_AT0: mac_op = '{en: 1'b1, clr: 1'b1, a: ALPHA_AMB,
                              b: {{2{r_amb[15]}}, r_amb, 16'd0}};
            S_AT1: mac_op = '{en: 1'b1, clr: 1'b0, a: BETA_AMB, b: MacBW'(r_s)};
            S_AH0: mac_op = '{en: 1'b1, clr: 1'b1, a: ALPHA_AMB, b: {1'b0, r_hum, 16'd0}};
            S_AH1: mac_op = '{en: 1'b1, clr: 1'b0, a: BETA_AMB, b: {1'b0, r_sh}};
            S_G0:  mac_op = '{en: 1'b1, clr: 1'b1, a: {1'b0, r_scale},
                              b: MacBW'(grad_in)};
            S_G1:  mac_op = '{en: r_grad_started, clr: 1'b1, a: ALPHA_GRAD,
                              b: MacBW'(adj)};
            S_G2:  mac_op = '{en: 1'b1, clr: 1'b0, a: BETA_GRAD, b: MacBW'(r_g)};
            S_SH0: mac_op = '{en: 1'b1, clr: 1'b1, a: {1'b0, r_factor}, b: MacBW'(r_g)};
            default: mac_op = '{en: 1'b0, clr: 1'b0, a: '0, b: '0};
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = (i_valid && !r_fin) ? S_START : S_IDLE;
            S_START: n_state = (r_fail || !r_amb_started) ? S_SM : S_AT0;
            S_AT0:   n_state = S_AT1;
            S_AT1:   n_state = S_AH0;
            S_AH0:   n_state = S_AH1;
            S_AH1:   n_state = S_AHW;
            S_AHW:   n_state = S_SM;
            S_SM:    n_state = (!r_fail && r_core_ok && r_corr_en) ? S_G0 : S_IDLE;
            S_G0:    n_state = S_G1;
            S_G1:    n_state = r_grad_started ? S_G2 : S_CAL;
            S_G2:    n_state = S_G3;
            S_G3:    n_state = S_CAL;
            S_CAL:   n_state = div_start ? S_DIV : S_SH0;
            S_DIV:   n_state = div_done ? S_SH0 : S_DIV;
            S_SH0:   n_state = S_SH1;
            S_SH1:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE) || r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fin          <= 1'b0;
            o_valid        <= 1'b0;
            r_corr_en      <= 1'b1;
            r_acal_en      <= 1'b0;
            r_ucorr        <= 13'sd0;
            r_dur          <= 32'd2700000;
            r_factor       <= 17'd0;
            r_s            <= 32'sd0;
            r_sh           <= 33'd0;
            r_g            <= 32'sd0;
            r_amb_started  <= 1'b0;
            r_grad_started <= 1'b0;
            r_first_done   <= 1'b0;
            r_cal_run      <= 1'b0;
            r_cal_start    <= 32'd0;
            r_base         <= 16'sd0;
            r_held_comp    <= 16'sd0;
            r_held_off     <= 16'sd0;
        end else begin
            r_state <= n_state;
            if (r_fin && (!o_valid || !i_stall)) begin
                r_fin              <= 1'b0;
                o_valid            <= 1'b1;
                o_compensated_temp <= r_held_comp;
                o_smoothed_temp    <= smoothed;
                o_applied_offset   <= r_held_off;
                o_humidity         <= r_hum_out;
                o_humidity_valid   <= r_hv;
                o_calibrating      <= r_cal_run;
                o_cal_event        <= r_ev;
                o_new_factor       <= r_factor;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CORR_EN:  r_corr_en <= i_cfg_data[0];
                    REG_ACAL_EN:  r_acal_en <= i_cfg_data[0];
                    REG_FACTOR:   r_factor  <= (i_cfg_data[16:0] > ONE_Q16)
                                               ? ONE_Q16 : i_cfg_data[16:0];
                    REG_USER_COR: r_ucorr   <= i_cfg_data[12:0];
                    REG_DURATION: r_dur     <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_fin) begin
                        r_amb     <= i_ambient_temp;
                        r_hum     <= i_ambient_humidity;
                        r_fail    <= i_read_failed;
                        r_core    <= i_core_temp;
                        r_core_ok <= i_core_present;
                        r_clk     <= i_clock_temp;
                        r_clk_ok  <= i_clock_present;
                        r_bright  <= i_brightness;
                        r_now     <= i_time_ms;
                        r_ev      <= EV_NONE;
                    end
                end
                S_START: begin
                    r_scale <= bright_scale(r_bright);
                    if (!r_first_done && r_core_ok && r_clk_ok) begin
                        r_first_done <= 1'b1;
                        if (r_acal_en && !r_fail && cdiff < HALF_DEG_Q88
                            && cdiff > -HALF_DEG_Q88) begin
                            r_cal_run   <= 1'b1;
                            r_base      <= r_amb;
                            r_cal_start <= r_now;
                            r_ev        <= EV_START;
                        end
                    end
                    if (!r_fail && !r_amb_started) begin
                        r_s           <= {r_amb, 16'd0};
                        r_sh          <= {r_hum, 16'd0};
                        r_amb_started <= 1'b1;
                    end
                end
                S_AH0: r_s  <= acc[47:16];
                S_AHW: r_sh <= acc[48:16];
                S_SM: begin
                    r_hum_out <= r_fail ? 17'd0 : r_sh[32:16];
                    r_hv      <= !r_fail;
                    if (!r_fail && !(r_core_ok && r_corr_en)) begin
                        r_held_off  <= 16'sd0;
                        r_held_comp <= smoothed;
                    end
                    if (r_fail || !(r_core_ok && r_corr_en)) begin
                        r_fin <= 1'b1;
                    end
                end
                S_G1: begin
                    if (!r_grad_started) begin
                        r_g            <= adj;
                        r_grad_started <= 1'b1;
                    end
                end
                S_G3: r_g <= acc[47:16];
                S_CAL: begin
                    if (r_cal_run && elapsed > r_dur) begin
                        r_cal_run <= 1'b0;
                        if (r_g > HALF_DEG_Q24) begin
                            r_ev <= EV_OK;
                            if (!(cal_diff > 17'sd0)) begin
                                r_factor <= 17'd0;
                            end
                        end else begin
                            r_ev <= EV_ABORT;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_factor <= div_q;
                    end
                end
                S_SH1: begin
                    r_held_off  <= sat16(offset);
                    r_held_comp <= sat16(comp);
                    r_fin       <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall)
        else $error("input taken while sequencer busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_factor <= ONE_Q16)
        else $error("factor above one");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_cal_event == EV_OK || o_cal_event == EV_ABORT) |-> !o_calibrating)
        else $error("calibration still running after it ended");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_humidity_valid |-> o_humidity == 17'd0)
        else $error("humidity shown on failed read");

endmodule

`default_nettype wire

// File: design/shtc_mac.sv
// ----------------------------------------------------------------------------
// shtc_mac: shared multiply-accumulate unit
// One signed multiplier feeding an accumulator register; clear starts a sum.
// ----------------------------------------------------------------------------
`default_nettype none

module shtc_mac
    import shtc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire t_mac_op                    i_op,
    output logic signed [MacAccW-1:0]       o_acc
);

    logic signed [MacAccW-1:0] r_acc;
    logic signed [MacAW+MacBW-1:0] prod;

    assign prod  = i_op.a * i_op.b;
    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            if (i_op.clr) begin
                r_acc <= MacAccW'(prod);
            end else begin
                r_acc <= r_acc + MacAccW'(prod);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/shtc_div.sv
// ----------------------------------------------------------------------------
// shtc_div: serial restoring divider
// One quotient bit per cycle of (dividend * 2^32) / divisor, saturated to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module shtc_div
    import shtc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [16:0]        i_dividend,
    input  wire logic [31:0]        i_divisor,
    output logic                    o_done,
    output logic [16:0]             o_quot
);

    logic [32:0] r_rem;
    logic [49:0] r_dq;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] shifted;
    logic        fits;

    assign shifted = {r_rem, r_dq[49]};
    assign fits    = shifted >= {2'b00, r_dvs};
    assign o_done  = r_done;
    assign o_quot  = (|r_dq[49:17] || r_dq[16:0] > ONE_Q16) ? ONE_Q16 : r_dq[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= 33'd0;
                r_dq   <= {1'b0, i_dividend, 32'd0};
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? 33'(shifted - {2'b00, r_dvs}) : shifted[32:0];
                r_dq  <= {r_dq[48:0], fits};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd49) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire
